[rtl/fdcp_pkg.sv]
// Package for the framed decimal command parser.
// Shared types, configuration register indexes and byte codes; no dependencies.
package fdcp_pkg;

  localparam int unsigned NumFields = 4;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QAw       = $clog2(QDepth);

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [2:0] RegStartByte      = 3'd0;
  localparam logic [2:0] RegEndByte        = 3'd1;
  localparam logic [2:0] RegFrameLimit     = 3'd2;
  localparam logic [2:0] RegDeviceTypeLow  = 3'd3;
  localparam logic [2:0] RegDeviceTypeHigh = 3'd4;
  localparam logic [2:0] RegSimpleTypeLow  = 3'd5;
  localparam logic [2:0] RegSimpleTypeHigh = 3'd6;
  localparam logic [2:0] RegResponseType   = 3'd7;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [10:0] frame_limit;
    logic [7:0]  device_type_low;
    logic [7:0]  device_type_high;
    logic [7:0]  simple_type_low;
    logic [7:0]  simple_type_high;
    logic [7:0]  response_type;
  } cfg_t;

  typedef struct packed {
    logic       is_start;
    logic       is_end;
    logic       is_digit;
    logic       is_minus;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    logic        is_error;
    logic [7:0]  cmd_type;
    logic [15:0] cmd_id;
    logic [15:0] device_id;
    logic [31:0] cmd_value;
  } result_t;

endpackage

[rtl/fdcp_front.sv]
// Front stage: registers each received byte and classifies it against the
// start/end codes and the digit and minus characters. Depends on fdcp_pkg.
module fdcp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fdcp_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_byte_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fdcp_pkg::item_t out_item_o
);

  logic            valid_q, valid_d;
  fdcp_pkg::item_t item_q, item_d;
  logic [3:0]      sub;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;
  assign sub         = in_byte_i[3:0] - fdcp_pkg::CharZero[3:0];

  always_comb begin
    item_d.is_start = (in_byte_i == cfg_i.start_byte);
    item_d.is_end   = (in_byte_i == cfg_i.end_byte);
    item_d.is_digit = (in_byte_i >= fdcp_pkg::CharZero) && (in_byte_i <= fdcp_pkg::CharNine);
    item_d.is_minus = (in_byte_i == fdcp_pkg::CharMinus);
    item_d.digit    = sub;
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

[rtl/fdcp_queue.sv]
// Short flop queue of classified items between the front and back stages.
// Depends on fdcp_pkg.
module fdcp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  fdcp_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output fdcp_pkg::item_t pop_item_o
);

  fdcp_pkg::item_t                 mem_q [fdcp_pkg::QDepth];
  logic [fdcp_pkg::QAw-1:0]        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [fdcp_pkg::QAw:0]          count_q, count_d;
  logic                            push, pop;

  assign push_ready_o = (count_q != (fdcp_pkg::QAw+1)'(fdcp_pkg::QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[rtl/fdcp_back.sv]
// Back stage: frame state, number accumulation and result formation, with an
// output register toward the result channel. Depends on fdcp_pkg.
module fdcp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fdcp_pkg::cfg_t   cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fdcp_pkg::item_t  in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fdcp_pkg::result_t out_result_o
);

  logic              in_frame_q, in_frame_d;
  logic [10:0]       byte_count_q, byte_count_d;
  logic [2:0]        field_index_q, field_index_d;
  logic              in_number_q, in_number_d;
  logic              is_negative_q, is_negative_d;
  logic [31:0]       acc_q, acc_d;
  logic [31:0]       fields_q [fdcp_pkg::NumFields];
  logic [31:0]       fields_d [fdcp_pkg::NumFields];
  logic [31:0]       fin [fdcp_pkg::NumFields];
  logic [2:0]        fin_index;
  logic [31:0]       number;
  logic [31:0]       acc_base;
  logic              out_valid_q, out_valid_d;
  fdcp_pkg::result_t result_q, result_d;
  logic              take;
  logic [7:0]        ftype;

  assign in_ready_o   = !out_valid_q || out_ready_i;
  assign take         = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_result_o = result_q;
  assign number       = is_negative_q ? (32'd0 - acc_q) : acc_q;
  assign ftype        = fin[0][7:0];
  assign acc_base     = in_number_q ? acc_q : 32'd0;

  // Fields after closing the number in progress.
  always_comb begin
    for (int i = 0; i < fdcp_pkg::NumFields; i++) begin
      fin[i] = fields_q[i];
      if (in_number_q && field_index_q == 3'(i)) begin
        fin[i] = number;
      end
    end
    fin_index = field_index_q;
    if (in_number_q && field_index_q < 3'(fdcp_pkg::NumFields)) begin
      fin_index = field_index_q + 3'd1;
    end
  end

  always_comb begin
    in_frame_d    = in_frame_q;
    byte_count_d  = byte_count_q;
    field_index_d = field_index_q;
    in_number_d   = in_number_q;
    is_negative_d = is_negative_q;
    acc_d         = acc_q;
    fields_d      = fields_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    result_d      = result_q;

    if (take) begin
      if (in_frame_q == 1'b0 && in_item_i.is_start) begin
        in_frame_d    = 1'b1;
        byte_count_d  = '0;
        field_index_d = '0;
        in_number_d   = 1'b0;
        is_negative_d = 1'b0;
        acc_d         = '0;
        for (int i = 0; i < fdcp_pkg::NumFields; i++) fields_d[i] = '0;
      end else if (in_item_i.is_end) begin
        out_valid_d        = 1'b1;
        result_d.is_error  = 1'b0;
        result_d.cmd_type  = ftype;
        result_d.cmd_id    = fin[1][15:0];
        result_d.device_id = '0;
        result_d.cmd_value = '0;
        if (ftype >= cfg_i.device_type_low && ftype <= cfg_i.device_type_high) begin
          result_d.device_id = fin[2][15:0];
          result_d.cmd_value = fin[3];
        end else if (ftype >= cfg_i.simple_type_low && ftype <= cfg_i.simple_type_high) begin
          result_d.cmd_value = fin[2];
        end
        in_frame_d    = 1'b0;
        byte_count_d  = '0;
        field_index_d = '0;
        in_number_d   = 1'b0;
        is_negative_d = 1'b0;
        acc_d         = '0;
        for (int i = 0; i < fdcp_pkg::NumFields; i++) fields_d[i] = '0;
      end else if (in_frame_q) begin
        if (byte_count_q >= cfg_i.frame_limit) begin
          out_valid_d        = 1'b1;
          result_d.is_error  = 1'b1;
          result_d.cmd_type  = cfg_i.response_type;
          result_d.cmd_id    = '0;
          result_d.device_id = '0;
          result_d.cmd_value = '0;
        end else begin
          byte_count_d = byte_count_q + 11'd1;
          if (in_item_i.is_digit) begin
            in_number_d = 1'b1;
            if (!in_number_q) begin
              is_negative_d = 1'b0;
            end
            acc_d = (acc_base << 3) + (acc_base << 1) + {28'd0, in_item_i.digit};
          end else begin
            fields_d      = fin;
            field_index_d = fin_index;
            in_number_d   = in_item_i.is_minus;
            is_negative_d = in_item_i.is_minus;
            acc_d         = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q    <= 1'b0;
      byte_count_q  <= '0;
      field_index_q <= '0;
      in_number_q   <= 1'b0;
      is_negative_q <= 1'b0;
      acc_q         <= '0;
      for (int i = 0; i < fdcp_pkg::NumFields; i++) fields_q[i] <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      in_frame_q    <= in_frame_d;
      byte_count_q  <= byte_count_d;
      field_index_q <= field_index_d;
      in_number_q   <= in_number_d;
      is_negative_q <= is_negative_d;
      acc_q         <= acc_d;
      fields_q      <= fields_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

endmodule

[rtl/framed_decimal_command_parser_top.sv]
// Framed decimal command parser, top level.
// Holds the configuration registers and joins fdcp_front, fdcp_queue and
// fdcp_back; depends on fdcp_pkg.
//
// Usage:
//   s_axis carries one received byte per transaction in tdata[7:0].
//   m_axis carries one result per transaction: tuser is the overflow error
//   flag, tdata holds type, id, device id and value.
//   cfg writes register cfg_index_i with cfg_data_i; write only while idle.
// Path: a byte that yields a result passes the front register, the queue
//   and the back output register before m_axis_tvalid rises.
// Throughput: one byte per cycle while m_axis_tready does not hold the
//   output register; the back stage updates the number accumulator
//   (times-ten add) and frame state for each byte.
// Reset: outside any frame, all numbers zero, queue empty, configuration at
//   start 59, end 13, limit 64, device class 0..255, simple class 0..0,
//   response type 0.
// Stall: while m_axis_tready is low the output register holds; the queue
//   and front register absorb up to five bytes before s_axis_tready drops.
module framed_decimal_command_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [7:0] cmd_type, [23:8] cmd_id,
                                      // [39:24] device_id, [71:40] cmd_value
  output logic        m_axis_tuser,   // [0] is_error
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  fdcp_pkg::cfg_t    cfg_q;
  fdcp_pkg::item_t   front_item, queue_item;
  fdcp_pkg::result_t result;
  logic              front_valid, front_ready, queue_valid, queue_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte       <= 8'd59;
      cfg_q.end_byte         <= 8'd13;
      cfg_q.frame_limit      <= 11'd64;
      cfg_q.device_type_low  <= 8'd0;
      cfg_q.device_type_high <= 8'd255;
      cfg_q.simple_type_low  <= 8'd0;
      cfg_q.simple_type_high <= 8'd0;
      cfg_q.response_type    <= 8'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fdcp_pkg::RegStartByte:      cfg_q.start_byte       <= cfg_data_i[7:0];
        fdcp_pkg::RegEndByte:        cfg_q.end_byte         <= cfg_data_i[7:0];
        fdcp_pkg::RegFrameLimit:     cfg_q.frame_limit      <= cfg_data_i;
        fdcp_pkg::RegDeviceTypeLow:  cfg_q.device_type_low  <= cfg_data_i[7:0];
        fdcp_pkg::RegDeviceTypeHigh: cfg_q.device_type_high <= cfg_data_i[7:0];
        fdcp_pkg::RegSimpleTypeLow:  cfg_q.simple_type_low  <= cfg_data_i[7:0];
        fdcp_pkg::RegSimpleTypeHigh: cfg_q.simple_type_high <= cfg_data_i[7:0];
        fdcp_pkg::RegResponseType:   cfg_q.response_type    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  fdcp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_item_o  (front_item)
  );

  fdcp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_item_o   (queue_item)
  );

  fdcp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (queue_valid),
    .in_ready_o   (queue_ready),
    .in_item_i    (queue_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (result)
  );

  assign m_axis_tuser = result.is_error;
  assign m_axis_tdata = {result.cmd_value, result.device_id, result.cmd_id, result.cmd_type};

endmodule

[tb/framed_decimal_command_parser_top_tb.sv]
// Self-checking testbench for framed_decimal_command_parser_top: directed table, then random
// frames under six register settings, every result compared with a cycle-free parser model.
// Depends on fdcp_pkg and the RTL of the block only.
module framed_decimal_command_parser_top_tb;

  localparam int unsigned PhaseItems  = 140;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned HoldAfter   = 300;
  localparam longint unsigned Timeout = 64'd5_000_000;

  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_BYTE_EXP,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [2:0]        reg_idx;
    logic [10:0]       data;
    fdcp_pkg::result_t exp;
  } dir_row_t;

  localparam fdcp_pkg::result_t CmdZero    = '0;
  localparam fdcp_pkg::result_t OverflowFF = '{is_error: 1'b1, cmd_type: 8'hFF, default: '0};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [10:0] cfg_data_i = '0;

  framed_decimal_command_parser_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  fdcp_pkg::cfg_t phase_cfg [6] = '{
    '{8'h3B, 8'h0D, 11'd64,   8'd0,   8'd255, 8'd0,   8'd0,   8'h00},
    '{8'h24, 8'h0A, 11'd16,   8'd20,  8'd40,  8'd30,  8'd60,  8'h55},
    '{8'hFF, 8'h00, 11'd1,    8'd255, 8'd255, 8'd0,   8'd254, 8'hFF},
    '{8'h3A, 8'h2F, 11'd1024, 8'd100, 8'd50,  8'd0,   8'd255, 8'h01},
    '{8'h2D, 8'h30, 11'd8,    8'd0,   8'd127, 8'd128, 8'd255, 8'h80},
    '{8'h23, 8'h23, 11'd3,    8'd0,   8'd0,   8'd1,   8'd1,   8'h07}
  };

  fdcp_pkg::cfg_t shadow_cfg;
  logic           frame_open;
  logic [10:0]    byte_cnt;
  logic [2:0]     field_idx;
  logic           num_open;
  logic           num_neg;
  logic [31:0]    num_acc;
  logic [31:0]    field_val [fdcp_pkg::NumFields];

  fdcp_pkg::result_t expected_cmd_q [$];
  logic [7:0]        rx_burst [$];
  dir_row_t          dir_rows [$];
  int                errors = 0;
  int                bytes_sent = 0;
  int                tx_idle_pct = 0;
  int                rx_idle_pct = 0;
  logic              rx_hold = 1'b0;

  function automatic void clear_frame();
    byte_cnt  = '0;
    field_idx = '0;
    num_open  = 1'b0;
    num_neg   = 1'b0;
    num_acc   = '0;
    field_val = '{default: '0};
  endfunction

  function automatic void close_number();
    if (!num_open) return;
    if (field_idx < fdcp_pkg::NumFields) begin
      field_val[field_idx[1:0]] = num_neg ? -num_acc : num_acc;
      field_idx = field_idx + 3'd1;
    end
    num_open = 1'b0;
    num_neg  = 1'b0;
    num_acc  = '0;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output fdcp_pkg::result_t r);
    logic [7:0] ty;
    r = '0;
    if (b == shadow_cfg.start_byte && !frame_open) begin
      frame_open = 1'b1;
      clear_frame();
      return 1'b0;
    end
    if (b == shadow_cfg.end_byte) begin
      close_number();
      ty = field_val[0][7:0];
      r.cmd_type = ty;
      r.cmd_id   = field_val[1][15:0];
      if (ty >= shadow_cfg.device_type_low && ty <= shadow_cfg.device_type_high) begin
        r.device_id = field_val[2][15:0];
        r.cmd_value = field_val[3];
      end else if (ty >= shadow_cfg.simple_type_low && ty <= shadow_cfg.simple_type_high) begin
        r.cmd_value = field_val[2];
      end
      frame_open = 1'b0;
      clear_frame();
      return 1'b1;
    end
    if (!frame_open) return 1'b0;
    if (byte_cnt >= shadow_cfg.frame_limit) begin
      r.is_error = 1'b1;
      r.cmd_type = shadow_cfg.response_type;
      return 1'b1;
    end
    byte_cnt = byte_cnt + 11'd1;
    if (b >= fdcp_pkg::CharZero && b <= fdcp_pkg::CharNine) begin
      if (!num_open) begin
        num_open = 1'b1;
        num_neg  = 1'b0;
        num_acc  = '0;
      end
      num_acc = num_acc * 32'd10 + 32'(b - fdcp_pkg::CharZero);
    end else if (b == fdcp_pkg::CharMinus) begin
      close_number();
      num_open = 1'b1;
      num_neg  = 1'b1;
      num_acc  = '0;
    end else begin
      close_number();
    end
    return 1'b0;
  endfunction

  function automatic dir_row_t row_byte(input logic [7:0] b);
    return '{kind: ROW_BYTE, reg_idx: '0, data: {3'b0, b}, exp: '0};
  endfunction

  function automatic dir_row_t row_byte_exp(input logic [7:0] b, input fdcp_pkg::result_t r);
    return '{kind: ROW_BYTE_EXP, reg_idx: '0, data: {3'b0, b}, exp: r};
  endfunction

  function automatic dir_row_t row_reg(input logic [2:0] idx, input logic [10:0] val);
    return '{kind: ROW_REG, reg_idx: idx, data: val, exp: '0};
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input fdcp_pkg::result_t typed_r);
    fdcp_pkg::result_t r;
    bit                got;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    got = parse_byte(b, r);
    if (typed) expected_cmd_q.push_back(typed_r);
    else if (got) expected_cmd_q.push_back(r);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
    s_axis_tvalid <= 1'b0;
    while (expected_cmd_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      fdcp_pkg::RegStartByte:      shadow_cfg.start_byte       = val[7:0];
      fdcp_pkg::RegEndByte:        shadow_cfg.end_byte         = val[7:0];
      fdcp_pkg::RegFrameLimit:     shadow_cfg.frame_limit      = val;
      fdcp_pkg::RegDeviceTypeLow:  shadow_cfg.device_type_low  = val[7:0];
      fdcp_pkg::RegDeviceTypeHigh: shadow_cfg.device_type_high = val[7:0];
      fdcp_pkg::RegSimpleTypeLow:  shadow_cfg.simple_type_low  = val[7:0];
      fdcp_pkg::RegSimpleTypeHigh: shadow_cfg.simple_type_high = val[7:0];
      default:                     shadow_cfg.response_type    = val[7:0];
    endcase
  endtask

  task automatic write_all(input fdcp_pkg::cfg_t c);
    write_reg(fdcp_pkg::RegStartByte,      {3'b0, c.start_byte});
    write_reg(fdcp_pkg::RegEndByte,        {3'b0, c.end_byte});
    write_reg(fdcp_pkg::RegFrameLimit,     c.frame_limit);
    write_reg(fdcp_pkg::RegDeviceTypeLow,  {3'b0, c.device_type_low});
    write_reg(fdcp_pkg::RegDeviceTypeHigh, {3'b0, c.device_type_high});
    write_reg(fdcp_pkg::RegSimpleTypeLow,  {3'b0, c.simple_type_low});
    write_reg(fdcp_pkg::RegSimpleTypeHigh, {3'b0, c.simple_type_high});
    write_reg(fdcp_pkg::RegResponseType,   {3'b0, c.response_type});
  endtask

  task automatic build_burst();
    int pick;
    int n_num;
    int n_dig;
    rx_burst.delete();
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      repeat ($urandom_range(1, 6)) rx_burst.push_back(8'($urandom_range(0, 255)));
      return;
    end
    rx_burst.push_back(shadow_cfg.start_byte);
    n_num = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 4) : $urandom_range(0, 6);
    for (int i = 0; i < n_num; i++) begin
      if ($urandom_range(0, 3) == 0) rx_burst.push_back(fdcp_pkg::CharMinus);
      if (i == 0) n_dig = $urandom_range(1, 3);
      else if ($urandom_range(0, 5) == 0) n_dig = $urandom_range(8, 12);
      else n_dig = $urandom_range(1, 5);
      if ($urandom_range(0, 15) == 0) n_dig = 0;
      repeat (n_dig) rx_burst.push_back(fdcp_pkg::CharZero + 8'($urandom_range(0, 9)));
      case ($urandom_range(0, 3))
        0:       rx_burst.push_back(",");
        1:       rx_burst.push_back(" ");
        2:       rx_burst.push_back(shadow_cfg.start_byte);
        default: rx_burst.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if (pick == 1 && shadow_cfg.frame_limit <= 80) begin
      repeat (int'(shadow_cfg.frame_limit) + $urandom_range(0, 3))
        rx_burst.push_back(8'($urandom_range(0, 255)));
    end
    if (pick != 2) rx_burst.push_back(shadow_cfg.end_byte);
  endtask

  always @(posedge clk_i) begin
    fdcp_pkg::result_t act;
    fdcp_pkg::result_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act.is_error  = m_axis_tuser;
      act.cmd_type  = m_axis_tdata[7:0];
      act.cmd_id    = m_axis_tdata[23:8];
      act.device_id = m_axis_tdata[39:24];
      act.cmd_value = m_axis_tdata[71:40];
      if (expected_cmd_q.size() == 0) begin
        $error("unexpected result: tuser %0d tdata %h", m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        exp = expected_cmd_q.pop_front();
        if (act.is_error !== exp.is_error) begin
          $error("is_error: expected %0d, actual %0d", exp.is_error, act.is_error);
          errors++;
        end
        if (act.cmd_type !== exp.cmd_type) begin
          $error("cmd_type: expected %0d, actual %0d", exp.cmd_type, act.cmd_type);
          errors++;
        end
        if (act.cmd_id !== exp.cmd_id) begin
          $error("cmd_id: expected %0d, actual %0d", $signed(exp.cmd_id), $signed(act.cmd_id));
          errors++;
        end
        if (act.device_id !== exp.device_id) begin
          $error("device_id: expected %0d, actual %0d",
                 $signed(exp.device_id), $signed(act.device_id));
          errors++;
        end
        if (act.cmd_value !== exp.cmd_value) begin
          $error("cmd_value: expected %0d, actual %0d",
                 $signed(exp.cmd_value), $signed(act.cmd_value));
          errors++;
        end
      end
    end
    m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    wait (bytes_sent >= HoldAfter);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #(Timeout);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int phase_bytes;
    shadow_cfg = phase_cfg[0];
    frame_open = 1'b0;
    clear_frame();
    dir_rows = '{
      row_byte("x"),
      row_byte_exp(8'h0D, CmdZero),
      row_byte(";"), row_byte("2"), row_byte("5"), row_byte("5"), row_byte("-"),
      row_byte("9"), row_byte(";"), row_byte("7"), row_byte("-"), row_byte("-"),
      row_byte("3"), row_byte(8'h0D),
      row_reg(fdcp_pkg::RegFrameLimit, 11'd0),
      row_reg(fdcp_pkg::RegResponseType, 11'd255),
      row_byte(";"), row_byte_exp("5", OverflowFF), row_byte_exp(8'h0D, CmdZero),
      row_reg(fdcp_pkg::RegStartByte, 11'd0),
      row_reg(fdcp_pkg::RegEndByte, 11'd0),
      row_reg(fdcp_pkg::RegFrameLimit, 11'd1024),
      row_reg(fdcp_pkg::RegDeviceTypeLow, 11'd10),
      row_reg(fdcp_pkg::RegDeviceTypeHigh, 11'd20),
      row_reg(fdcp_pkg::RegSimpleTypeLow, 11'd0),
      row_reg(fdcp_pkg::RegSimpleTypeHigh, 11'd255),
      row_byte(8'h00), row_byte("1"), row_byte("5"), row_byte(" "), row_byte("9"),
      row_byte("0"), row_byte(" "), row_byte("1"), row_byte(8'h00)
    };
    tx_idle_pct = 8;
    rx_idle_pct = 45;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        write_reg(dir_rows[i].reg_idx, dir_rows[i].data);
      end else begin
        send_byte(dir_rows[i].data[7:0], dir_rows[i].kind == ROW_BYTE_EXP, dir_rows[i].exp);
      end
    end

    for (int p = 0; p < 6; p++) begin
      write_all(phase_cfg[p]);
      if (p < 2) begin
        tx_idle_pct = 8;
        rx_idle_pct = 45;
      end else if (p < 4) begin
        tx_idle_pct = 45;
        rx_idle_pct = 8;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      phase_bytes = 0;
      while (phase_bytes < PhaseItems) begin
        build_burst();
        foreach (rx_burst[i]) send_byte(rx_burst[i], 1'b0, '0);
        phase_bytes += rx_burst.size();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_cmd_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
